// ===== rtl/cartridge_mapper_irq_tone_core_defines.svh =====
// Assertion macros shared by the RTL of the cartridge mapper core.
// Define ASSERT_OFF to compile the checks away.
`ifndef CARTRIDGE_MAPPER_IRQ_TONE_CORE_DEFINES_SVH
`define CARTRIDGE_MAPPER_IRQ_TONE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cmit_pkg.sv =====
`timescale 1ns / 1ps

package cmit_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0]
    {
        REQ_WRITE   = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_CPU_MAP = 2'd2,
        REQ_PPU_MAP = 2'd3
    } req_t;

    // What a looked-up address reaches.
    typedef enum logic [1:0]
    {
        KIND_ROM  = 2'd0,
        KIND_RAM  = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    // Mapper command register codes.
    localparam logic [3:0] CMD_CHR_LAST   = 4'h7;
    localparam logic [3:0] CMD_WINDOW     = 4'h8;
    localparam logic [3:0] CMD_PRG_0      = 4'h9;
    localparam logic [3:0] CMD_PRG_1      = 4'hA;
    localparam logic [3:0] CMD_PRG_2      = 4'hB;
    localparam logic [3:0] CMD_MIRROR     = 4'hC;
    localparam logic [3:0] CMD_IRQ_CTRL   = 4'hD;
    localparam logic [3:0] CMD_IRQ_CNT_LO = 4'hE;
    localparam logic [3:0] CMD_IRQ_CNT_HI = 4'hF;

    // Audio register codes.
    localparam logic [3:0] AUD_PERIOD_LAST = 4'h5;
    localparam logic [3:0] AUD_MUTE        = 4'h7;
    localparam logic [3:0] AUD_VOL_A       = 4'h8;
    localparam logic [3:0] AUD_VOL_C       = 4'hA;

    // Window register bits.
    localparam int WIN_RAM_SEL = 6;
    localparam int WIN_RAM_EN  = 7;

    localparam int NUM_CHR  = 8;
    localparam int NUM_PRG  = 3;
    localparam int NUM_TONE = 3;

    localparam logic [7:0] LAST_BANK_RESET = 8'hFF;
    localparam logic [7:0] WINDOW_RESET    = 8'h40;

    // Bank and target of one bus lookup.
    typedef struct packed
    {
        logic [7:0] bank;
        kind_t      kind;
    } map_t;

    // One result item.
    typedef struct packed
    {
        logic [4:0] level_c;
        logic [4:0] level_b;
        logic [4:0] level_a;
        logic       ram_write_ok;
        kind_t      target_kind;
        logic [7:0] mapped_bank;
        logic [1:0] mirroring;
        logic       irq_line;
    } result_t;

    // CPU address map with the given bank settings.
    function automatic map_t cpu_map(
        input logic [15:0] addr,
        input logic [7:0]  window,
        input logic [5:0]  prg0,
        input logic [5:0]  prg1,
        input logic [5:0]  prg2,
        input logic [7:0]  last_bank
    );
        map_t m;
        m.bank = 8'd0;
        m.kind = KIND_NONE;
        case (addr[15:13]) inside
            [3'd0:3'd2]:
            begin
                m.bank = 8'd0;
                m.kind = KIND_NONE;
            end
            3'd3:
            begin
                if (!window[WIN_RAM_SEL])
                begin
                    m.bank = {2'b00, window[5:0]};
                    m.kind = KIND_ROM;
                end
                else if (window[WIN_RAM_EN])
                begin
                    m.bank = {2'b00, window[5:0]};
                    m.kind = KIND_RAM;
                end
            end
            3'd4:
            begin
                m.bank = {2'b00, prg0};
                m.kind = KIND_ROM;
            end
            3'd5:
            begin
                m.bank = {2'b00, prg1};
                m.kind = KIND_ROM;
            end
            3'd6:
            begin
                m.bank = {2'b00, prg2};
                m.kind = KIND_ROM;
            end
            default:
            begin
                m.bank = last_bank;
                m.kind = KIND_ROM;
            end
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/cartridge_mapper_irq_tone_core.sv =====
`timescale 1ns / 1ps
// Cartridge mapper core with cycle IRQ counter and three square tone channels.
// Input channel (s_*): one item per CPU write, CPU cycle tick, CPU map lookup or
// PPU map lookup; s_tuser carries the request kind, s_tdata the address and data.
// Output channel (m_*): exactly one result item per input item, in order, with
// the IRQ level, mirroring, mapped bank, target kind, RAM-write gate and the
// three tone level indexes as they stand after that item.
// Configuration channel (cfg_*): writes the bank fixed at E000h; always ready,
// to be used only while no item is in flight.
// A result is registered in the output register, or in the skid register on a stall.
// Throughput: one item per clock while s_tready is high. All state is updated
// by one pass of logic from the item into the state and output or skid registers.
// When the receiver stalls, one further item is held in a skid register; then
// s_tready falls until the output drains, so no item is lost.
// Reset (rst_n low) returns every setting to its power-up value: banks zero,
// window on RAM bank 0 with writes disabled, last bank FFh, IRQ and tones idle.
`include "cartridge_mapper_irq_tone_core_defines.svh"

module cartridge_mapper_irq_tone_core
(
    input  logic        clk,
    input  logic        rst_n,

    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // req_type[1:0]

    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // irq_line[0], mirroring[2:1], mapped_bank[10:3],
                                   // ram_write_ok[11], level_a[16:12],
                                   // level_b[21:17], level_c[26:22], zero[31:27]
    output logic [1:0]  m_tuser,   // target_kind[1:0]

    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // last_program_bank
);

    // State registers
    logic [7:0]  last_bank_reg;
    logic [3:0]  cmd_reg, cmd_next;
    logic [3:0]  audio_cmd_reg, audio_cmd_next;
    logic [7:0]  chr_bank_reg [cmit_pkg::NUM_CHR];
    logic [7:0]  chr_bank_next [cmit_pkg::NUM_CHR];
    logic [7:0]  window_reg, window_next;
    logic [5:0]  prg_bank_reg [cmit_pkg::NUM_PRG];
    logic [5:0]  prg_bank_next [cmit_pkg::NUM_PRG];
    logic [1:0]  mirror_reg, mirror_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        irq_count_en_reg, irq_count_en_next;
    logic        irq_clear_reg, irq_clear_next;
    logic [15:0] irq_counter_reg, irq_counter_next;
    logic        irq_out_reg, irq_out_next;
    logic [15:0] tone_period_reg [cmit_pkg::NUM_TONE];
    logic [15:0] tone_period_next [cmit_pkg::NUM_TONE];
    logic        tone_mute_reg [cmit_pkg::NUM_TONE];
    logic        tone_mute_next [cmit_pkg::NUM_TONE];
    logic [3:0]  tone_volume_reg [cmit_pkg::NUM_TONE];
    logic [3:0]  tone_volume_next [cmit_pkg::NUM_TONE];
    logic        tone_phase_reg [cmit_pkg::NUM_TONE];
    logic        tone_phase_next [cmit_pkg::NUM_TONE];
    logic [15:0] tone_count_reg [cmit_pkg::NUM_TONE];
    logic [15:0] tone_count_next [cmit_pkg::NUM_TONE];
    logic [3:0]  tone_prescale_reg [cmit_pkg::NUM_TONE];
    logic [3:0]  tone_prescale_next [cmit_pkg::NUM_TONE];
    logic [4:0]  tone_level_reg [cmit_pkg::NUM_TONE];
    logic [4:0]  tone_level_next [cmit_pkg::NUM_TONE];

    // Output and skid registers
    cmit_pkg::result_t out_reg, out_next;
    cmit_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    // Item fields and handshakes
    cmit_pkg::req_t    req;
    logic [15:0]       addr;
    logic [7:0]        wdata;
    logic              accept;
    logic              pop;
    cmit_pkg::map_t    map_res;
    cmit_pkg::result_t result;
    logic [15:0]       tone_step;
    logic [15:0]       irq_dec;

    assign req    = cmit_pkg::req_t'(s_tuser);
    assign addr   = s_tdata[15:0];
    assign wdata  = s_tdata[23:16];
    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.level_c, out_reg.level_b, out_reg.level_a,
                       out_reg.ram_write_ok, out_reg.mapped_bank, out_reg.mirroring,
                       out_reg.irq_line};
    assign m_tuser  = out_reg.target_kind;

    // Next state of the mapper, IRQ and tone registers for an accepted item.
    always_comb
    begin
        cmd_next          = cmd_reg;
        audio_cmd_next    = audio_cmd_reg;
        chr_bank_next     = chr_bank_reg;
        window_next       = window_reg;
        prg_bank_next     = prg_bank_reg;
        mirror_next       = mirror_reg;
        irq_enable_next   = irq_enable_reg;
        irq_count_en_next = irq_count_en_reg;
        irq_clear_next    = irq_clear_reg;
        irq_counter_next  = irq_counter_reg;
        irq_out_next      = irq_out_reg;
        tone_period_next  = tone_period_reg;
        tone_mute_next    = tone_mute_reg;
        tone_volume_next  = tone_volume_reg;
        tone_phase_next   = tone_phase_reg;
        tone_count_next   = tone_count_reg;
        tone_prescale_next = tone_prescale_reg;
        tone_level_next   = tone_level_reg;
        tone_step         = 16'd0;
        irq_dec           = irq_counter_reg - 16'd1;

        if (accept)
        begin
            case (req)
                cmit_pkg::REQ_WRITE:
                begin
                    case (addr[15:13])
                        3'd4:
                        begin
                            cmd_next = wdata[3:0];
                        end
                        3'd5:
                        begin
                            // Parameter write to the selected mapper register
                            case (cmd_reg) inside
                                [4'h0:cmit_pkg::CMD_CHR_LAST]:
                                    chr_bank_next[cmd_reg[2:0]] = wdata;
                                cmit_pkg::CMD_WINDOW:
                                    window_next = wdata;
                                cmit_pkg::CMD_PRG_0:
                                    prg_bank_next[0] = wdata[5:0];
                                cmit_pkg::CMD_PRG_1:
                                    prg_bank_next[1] = wdata[5:0];
                                cmit_pkg::CMD_PRG_2:
                                    prg_bank_next[2] = wdata[5:0];
                                cmit_pkg::CMD_MIRROR:
                                    mirror_next = wdata[1:0];
                                cmit_pkg::CMD_IRQ_CTRL:
                                begin
                                    irq_enable_next   = wdata[0];
                                    irq_count_en_next = wdata[7];
                                    irq_clear_next    = 1'b1;
                                end
                                cmit_pkg::CMD_IRQ_CNT_LO:
                                    irq_counter_next = {irq_counter_reg[15:8], wdata};
                                default:
                                    irq_counter_next = {wdata, irq_counter_reg[7:0]};
                            endcase
                        end
                        3'd6:
                        begin
                            audio_cmd_next = wdata[3:0];
                        end
                        3'd7:
                        begin
                            // Audio register write; unused codes are ignored
                            case (audio_cmd_reg) inside
                                [4'h0:cmit_pkg::AUD_PERIOD_LAST]:
                                begin
                                    if (audio_cmd_reg[0])
                                        tone_period_next[audio_cmd_reg[2:1]] =
                                            {wdata, tone_period_reg[audio_cmd_reg[2:1]][7:0]};
                                    else
                                        tone_period_next[audio_cmd_reg[2:1]] =
                                            {tone_period_reg[audio_cmd_reg[2:1]][15:8], wdata};
                                end
                                cmit_pkg::AUD_MUTE:
                                begin
                                    tone_mute_next[0] = wdata[0];
                                    tone_mute_next[1] = wdata[1];
                                    tone_mute_next[2] = wdata[2];
                                end
                                [cmit_pkg::AUD_VOL_A:cmit_pkg::AUD_VOL_C]:
                                    tone_volume_next[audio_cmd_reg[1:0]] = wdata[3:0];
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                cmit_pkg::REQ_TICK:
                begin
                    // Tone channels: prescale of 16, then period compare
                    for (int ch = 0; ch < cmit_pkg::NUM_TONE; ch++)
                    begin
                        tone_prescale_next[ch] = tone_prescale_reg[ch] + 4'd1;
                        if (tone_prescale_next[ch] == 4'd0)
                        begin
                            tone_step = tone_count_reg[ch] + 16'd1;
                            tone_count_next[ch] = tone_step;
                            if (tone_step >= tone_period_reg[ch])
                            begin
                                tone_phase_next[ch] = !tone_phase_reg[ch];
                                tone_count_next[ch] = 16'd0;
                                if (tone_phase_next[ch] && !tone_mute_reg[ch])
                                    tone_level_next[ch] = {tone_volume_reg[ch],
                                                           (tone_volume_reg[ch] != 4'd0)};
                                else
                                    tone_level_next[ch] = 5'd0;
                            end
                        end
                    end
                    // Pending acknowledge first, then the down-counter
                    if (irq_clear_reg)
                    begin
                        irq_out_next   = 1'b0;
                        irq_clear_next = 1'b0;
                    end
                    if (irq_count_en_reg)
                    begin
                        irq_counter_next = irq_dec;
                        if (irq_dec == 16'hFFFF)
                            irq_out_next = irq_enable_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of the item, taken from the settings after it has taken effect.
    always_comb
    begin
        map_res = cmit_pkg::cpu_map(addr, window_next, prg_bank_next[0],
                                    prg_bank_next[1], prg_bank_next[2], last_bank_reg);
        result.irq_line     = irq_out_next;
        result.mirroring    = mirror_next;
        result.ram_write_ok = window_next[cmit_pkg::WIN_RAM_SEL]
                              && window_next[cmit_pkg::WIN_RAM_EN];
        result.level_a      = tone_level_next[0];
        result.level_b      = tone_level_next[1];
        result.level_c      = tone_level_next[2];
        result.mapped_bank  = 8'd0;
        result.target_kind  = cmit_pkg::KIND_NONE;
        case (req)
            cmit_pkg::REQ_WRITE,
            cmit_pkg::REQ_CPU_MAP:
            begin
                result.mapped_bank = map_res.bank;
                result.target_kind = map_res.kind;
            end
            cmit_pkg::REQ_PPU_MAP:
            begin
                if (!addr[13])
                begin
                    result.mapped_bank = chr_bank_reg[addr[12:10]];
                    result.target_kind = cmit_pkg::KIND_ROM;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register with a one-entry skid stage behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    // Handshake control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Fixed bank at E000h, written through the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_bank_reg <= cmit_pkg::LAST_BANK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            last_bank_reg <= cfg_data;
        end
    end

    // Mapper, IRQ and tone state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg          <= 4'd0;
            audio_cmd_reg    <= 4'd0;
            window_reg       <= cmit_pkg::WINDOW_RESET;
            mirror_reg       <= 2'd0;
            irq_enable_reg   <= 1'b0;
            irq_count_en_reg <= 1'b0;
            irq_clear_reg    <= 1'b0;
            irq_counter_reg  <= 16'd0;
            irq_out_reg      <= 1'b0;
            for (int i = 0; i < cmit_pkg::NUM_CHR; i++)
            begin
                chr_bank_reg[i] <= 8'd0;
            end
            for (int i = 0; i < cmit_pkg::NUM_PRG; i++)
            begin
                prg_bank_reg[i] <= 6'd0;
            end
            for (int i = 0; i < cmit_pkg::NUM_TONE; i++)
            begin
                tone_period_reg[i]   <= 16'd0;
                tone_mute_reg[i]     <= 1'b0;
                tone_volume_reg[i]   <= 4'd0;
                tone_phase_reg[i]    <= 1'b0;
                tone_count_reg[i]    <= 16'd0;
                tone_prescale_reg[i] <= 4'd0;
                tone_level_reg[i]    <= 5'd0;
            end
        end
        else
        begin
            cmd_reg           <= cmd_next;
            audio_cmd_reg     <= audio_cmd_next;
            window_reg        <= window_next;
            mirror_reg        <= mirror_next;
            irq_enable_reg    <= irq_enable_next;
            irq_count_en_reg  <= irq_count_en_next;
            irq_clear_reg     <= irq_clear_next;
            irq_counter_reg   <= irq_counter_next;
            irq_out_reg       <= irq_out_next;
            chr_bank_reg      <= chr_bank_next;
            prg_bank_reg      <= prg_bank_next;
            tone_period_reg   <= tone_period_next;
            tone_mute_reg     <= tone_mute_next;
            tone_volume_reg   <= tone_volume_next;
            tone_phase_reg    <= tone_phase_next;
            tone_count_reg    <= tone_count_next;
            tone_prescale_reg <= tone_prescale_next;
            tone_level_reg    <= tone_level_next;
        end
    end

    // The skid entry is only ever filled behind a waiting output item.
    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)

    // A RAM target can only be reported while RAM writes are enabled.
    `ASSERT_IMPLY(a_ram_kind_gate, clk, rst_n,
        out_valid_reg && (out_reg.target_kind == cmit_pkg::KIND_RAM),
        out_reg.ram_write_ok)

    // A non-zero tone level on channel A is always an odd index.
    `ASSERT_IMPLY(a_level_odd, clk, rst_n,
        out_valid_reg && (out_reg.level_a != 5'd0), out_reg.level_a[0])

    // Any tick consumes a pending IRQ acknowledge.
    `ASSERT_NEXT(a_tick_clears_ack, clk, rst_n,
        accept && (req == cmit_pkg::REQ_TICK), !irq_clear_reg)

endmodule
